// ----- design/two_slot_tile_occupancy_table_macros.svh -----
// Assertion macros shared by the tile occupancy table RTL.
`ifndef TWO_SLOT_TILE_OCCUPANCY_TABLE_MACROS_SVH
`define TWO_SLOT_TILE_OCCUPANCY_TABLE_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define TSOT_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A consequent that holds in the same cycle as its antecedent.
`define TSOT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A consequent that holds in the cycle after its antecedent.
`define TSOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/tsot_pkg.sv -----
// Shared constants, codes and types of the tile occupancy table.
`default_nettype none

package tsot_pkg;

   // Default geometry and id storage width.
   localparam int GRID_WIDTH_DEF     = 64;
   localparam int GRID_HEIGHT_DEF    = 64;
   localparam int ENTITY_ID_BITS_DEF = 10;

   // Fixed channel field widths.
   localparam int KIND_W   = 2;
   localparam int COORD_W  = 6;
   localparam int TARGET_W = 12;
   localparam int ID_PORT_W = 10;
   localparam int TYPE_W   = 2;
   localparam int STATUS_W = 2;

   // Operation codes.
   localparam logic [KIND_W-1:0] KIND_PLACE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MOVE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIND  = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_MOVE_WR
   } tsot_state_type;

   // Decision of the evaluation logic for one transaction.
   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 slot;
      logic [ID_PORT_W-1:0] found_id;
      logic                 wr_prim;
      logic                 wr_src;
   } tsot_eval_type;

endpackage

`default_nettype wire

// ----- design/tsot_if.sv -----
// Request and response channel interfaces of the tile occupancy table.
`default_nettype none

interface tsot_req_if;
   logic                             valid;
   logic                             ready;
   logic [tsot_pkg::KIND_W-1:0]      kind;
   logic [tsot_pkg::COORD_W-1:0]     tile_x;
   logic [tsot_pkg::COORD_W-1:0]     tile_y;
   logic [tsot_pkg::TARGET_W-1:0]    target_tile;
   logic                             current_slot;
   logic [tsot_pkg::ID_PORT_W-1:0]   entity_id;
   logic [tsot_pkg::TYPE_W-1:0]      entity_type;

   modport source (
      output valid, kind, tile_x, tile_y, target_tile, current_slot, entity_id, entity_type,
      input  ready
   );
   modport sink (
      input  valid, kind, tile_x, tile_y, target_tile, current_slot, entity_id, entity_type,
      output ready
   );
endinterface

interface tsot_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tsot_pkg::STATUS_W-1:0]    status;
   logic                             slot;
   logic [tsot_pkg::ID_PORT_W-1:0]   found_id;

   modport source (output valid, status, slot, found_id, input ready);
   modport sink   (input valid, status, slot, found_id, output ready);
endinterface

`default_nettype wire

// ----- design/tsot_ram.sv -----
// Generic single-write, dual-read synchronous RAM with registered read data.
`default_nettype none

module tsot_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

// ----- design/tsot_eval.sv -----
// Slot selection, type search and write-back entry formation for one transaction.
`default_nettype none

module tsot_eval #(
   parameter int ENTITY_ID_BITS = tsot_pkg::ENTITY_ID_BITS_DEF
) (
   input  wire logic [tsot_pkg::KIND_W-1:0]       kind,
   input  wire logic                              prim_ok,
   input  wire logic                              src_ok,
   input  wire logic                              same_tile,
   input  wire logic                              cur_slot,
   input  wire logic [ENTITY_ID_BITS-1:0]         ent_id,
   input  wire logic [tsot_pkg::TYPE_W-1:0]       ent_type,
   input  wire logic [2*(ENTITY_ID_BITS+3)-1:0]   prim_entry,
   input  wire logic [2*(ENTITY_ID_BITS+3)-1:0]   src_entry,
   output logic      [2*(ENTITY_ID_BITS+3)-1:0]   prim_wr_entry,
   output logic      [2*(ENTITY_ID_BITS+3)-1:0]   src_wr_entry,
   output tsot_pkg::tsot_eval_type                ctl
);

   localparam int SLOT_W  = ENTITY_ID_BITS + 3;
   localparam int ENTRY_W = 2 * SLOT_W;
   localparam int IdPortW = tsot_pkg::ID_PORT_W;

   logic [SLOT_W-1:0]  p0, p1, s0, s1, new_slot;
   logic [ENTRY_W-1:0] base;
   logic               free_any, free_sel, match0, match1, fold_clear;

   assign p0 = prim_entry[SLOT_W-1:0];
   assign p1 = prim_entry[ENTRY_W-1:SLOT_W];
   assign s0 = src_entry[SLOT_W-1:0];
   assign s1 = src_entry[ENTRY_W-1:SLOT_W];

   // Valid bit on top, then type, then id.
   assign new_slot = {1'b1, ent_type, ent_id};

   assign free_any = prim_ok && (!p0[SLOT_W-1] || !p1[SLOT_W-1]);
   assign free_sel = p0[SLOT_W-1];

   // When source and target are the same tile, the source clear is merged into the
   // single write of the target entry.
   assign fold_clear = (kind == tsot_pkg::KIND_MOVE) && src_ok && same_tile;

   always_comb begin
      base = prim_entry;
      if (fold_clear) begin
         base = cur_slot ? {{SLOT_W{1'b0}}, p0} : {p1, {SLOT_W{1'b0}}};
      end
      prim_wr_entry = free_sel ? {new_slot, base[SLOT_W-1:0]}
                               : {base[ENTRY_W-1:SLOT_W], new_slot};
   end

   assign src_wr_entry = cur_slot ? {{SLOT_W{1'b0}}, s0} : {s1, {SLOT_W{1'b0}}};

   assign match0 = prim_ok && p0[SLOT_W-1] && (p0[SLOT_W-2:ENTITY_ID_BITS] == ent_type);
   assign match1 = prim_ok && p1[SLOT_W-1] && (p1[SLOT_W-2:ENTITY_ID_BITS] == ent_type);

   always_comb begin
      ctl          = '0;
      ctl.status   = tsot_pkg::STATUS_NOT_FOUND;
      unique case (kind)
         tsot_pkg::KIND_PLACE: begin
            if (free_any) begin
               ctl.status  = tsot_pkg::STATUS_OK;
               ctl.slot    = free_sel;
               ctl.wr_prim = 1'b1;
            end else begin
               ctl.status = tsot_pkg::STATUS_FULL;
            end
         end
         tsot_pkg::KIND_MOVE: begin
            if (free_any) begin
               ctl.status  = tsot_pkg::STATUS_OK;
               ctl.slot    = free_sel;
               ctl.wr_prim = 1'b1;
               ctl.wr_src  = src_ok && !same_tile;
            end else begin
               ctl.status = tsot_pkg::STATUS_FULL;
            end
         end
         tsot_pkg::KIND_FIND: begin
            if (match0) begin
               ctl.status   = tsot_pkg::STATUS_OK;
               ctl.found_id = IdPortW'(p0[ENTITY_ID_BITS-1:0]);
            end else if (match1) begin
               ctl.status   = tsot_pkg::STATUS_OK;
               ctl.slot     = 1'b1;
               ctl.found_id = IdPortW'(p1[ENTITY_ID_BITS-1:0]);
            end
         end
         default: begin
            ctl.status = tsot_pkg::STATUS_NOT_FOUND;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/two_slot_tile_occupancy_table.sv -----
// Top level of the two-slot tile occupancy table: sequencer, tile RAM and response register.
//
//   Channel | Direction | Payload                                                   | Handshake
//   req_ch  | in        | kind tile_x tile_y target_tile current_slot id type        | valid/ready
//   rsp_ch  | out       | status slot found_id                                      | valid/ready
//
// A place or find transaction reads the RAM, then evaluates and (for a place) writes back; a
// move between two different tiles adds the move-write state, since the single RAM write port
// must clear the source slot and then fill the target slot. A move within one tile is a single
// merged write. After reset all GRID_WIDTH * GRID_HEIGHT tiles (4096 at the default size) are
// swept to empty, one tile per cycle; no request is accepted during the sweep.
// A stalled response holds the sequencer in its evaluate state; the next request can still be
// accepted while a finished response waits in the output register.
`default_nettype none

`include "two_slot_tile_occupancy_table_macros.svh"

module two_slot_tile_occupancy_table #(
   parameter int GRID_WIDTH     = tsot_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT    = tsot_pkg::GRID_HEIGHT_DEF,
   parameter int ENTITY_ID_BITS = tsot_pkg::ENTITY_ID_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tsot_req_if.sink    req_ch,
   tsot_rsp_if.source  rsp_ch
);

   // Tile index range and RAM geometry.
   localparam int unsigned TILE_COUNT = GRID_WIDTH * GRID_HEIGHT;
   localparam int ADDR_W  = $clog2(TILE_COUNT);
   localparam int COORD_MAX = (1 << tsot_pkg::COORD_W) - 1;
   localparam int SRC_W   = $clog2(COORD_MAX + GRID_WIDTH * COORD_MAX + 1);
   localparam int SLOT_W  = ENTITY_ID_BITS + 3;
   localparam int ENTRY_W = 2 * SLOT_W;

   tsot_pkg::tsot_state_type state_ff, state_in;

   // Transaction registers, loaded when a request is accepted.
   logic [tsot_pkg::KIND_W-1:0] kind_ff;
   logic [ADDR_W-1:0]           prim_addr_ff, src_addr_ff;
   logic                        prim_ok_ff, src_ok_ff, same_ff, cur_ff;
   logic [ENTITY_ID_BITS-1:0]   id_ff;
   logic [tsot_pkg::TYPE_W-1:0] type_ff;

   logic [ADDR_W-1:0]           clr_cnt_ff;

   // Response register.
   logic                          rsp_valid_ff;
   logic [tsot_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                          rsp_slot_ff;
   logic [tsot_pkg::ID_PORT_W-1:0] rsp_found_id_ff;

   logic [SRC_W-1:0]   req_src_idx;
   logic               req_src_ok, req_tgt_ok, req_is_move;
   logic               req_ready, req_accept, out_free, rsp_load;
   logic               ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr_a, ram_rd_addr_b;
   logic [ENTRY_W-1:0] ram_wr_data, prim_entry, src_entry, prim_wr_entry, src_wr_entry;
   tsot_pkg::tsot_eval_type ctl;

   // Source tile index with no clamping: a wide column wraps into later rows.
   assign req_src_idx = SRC_W'(req_ch.tile_x) + SRC_W'(GRID_WIDTH) * SRC_W'(req_ch.tile_y);
   assign req_src_ok  = 32'(req_src_idx) < TILE_COUNT;
   assign req_tgt_ok  = 32'(req_ch.target_tile) < TILE_COUNT;
   assign req_is_move = (req_ch.kind == tsot_pkg::KIND_MOVE);

   assign req_accept = req_ch.valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   // Port A reads the tile that gets the new slot (or is searched); port B reads the
   // source tile of a move so that its other slot survives the clear.
   assign ram_rd_addr_a = req_is_move ? ADDR_W'(req_ch.target_tile) : ADDR_W'(req_src_idx);
   assign ram_rd_addr_b = ADDR_W'(req_src_idx);

   tsot_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TILE_COUNT)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_a (prim_entry),
      .rd_data_b (src_entry)
   );

   tsot_eval #(
      .ENTITY_ID_BITS (ENTITY_ID_BITS)
   ) u_eval (
      .kind          (kind_ff),
      .prim_ok       (prim_ok_ff),
      .src_ok        (src_ok_ff),
      .same_tile     (same_ff),
      .cur_slot      (cur_ff),
      .ent_id        (id_ff),
      .ent_type      (type_ff),
      .prim_entry    (prim_entry),
      .src_entry     (src_entry),
      .prim_wr_entry (prim_wr_entry),
      .src_wr_entry  (src_wr_entry),
      .ctl           (ctl)
   );

   // Next state. Each write lands before the next read can be issued, so
   // back-to-back transactions on the same tile need no forwarding.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsot_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == ADDR_W'(TILE_COUNT - 1)) begin
               state_in = tsot_pkg::ST_IDLE;
            end
         end
         tsot_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = tsot_pkg::ST_EVAL;
            end
         end
         tsot_pkg::ST_EVAL: begin
            if (out_free) begin
               state_in = (ctl.wr_src && ctl.wr_prim) ? tsot_pkg::ST_MOVE_WR
                                                      : tsot_pkg::ST_IDLE;
            end
         end
         tsot_pkg::ST_MOVE_WR: begin
            state_in = tsot_pkg::ST_IDLE;
         end
         default: begin
            state_in = tsot_pkg::ST_CLEAR;
         end
      endcase
   end

   // Outputs of the sequencer: RAM control and response load.
   always_comb begin
      req_ready   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = prim_addr_ff;
      ram_wr_data = prim_wr_entry;
      rsp_load    = 1'b0;
      unique case (state_ff)
         tsot_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
         end
         tsot_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            ram_rd_en = req_ch.valid;
         end
         tsot_pkg::ST_EVAL: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (ctl.wr_src) begin
                  // The source clear goes first; the target fill follows next cycle.
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = src_addr_ff;
                  ram_wr_data = src_wr_entry;
               end else if (ctl.wr_prim) begin
                  ram_wr_en = 1'b1;
               end
            end
         end
         tsot_pkg::ST_MOVE_WR: begin
            // Read data and transaction registers are unchanged, so the target entry
            // computed in the evaluate cycle is still on prim_wr_entry.
            ram_wr_en = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_ch.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsot_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == tsot_pkg::ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff      <= req_ch.kind;
         prim_addr_ff <= ram_rd_addr_a;
         src_addr_ff  <= ram_rd_addr_b;
         prim_ok_ff   <= req_is_move ? req_tgt_ok : req_src_ok;
         src_ok_ff    <= req_src_ok;
         same_ff      <= (32'(req_src_idx) == 32'(req_ch.target_tile));
         cur_ff       <= req_ch.current_slot;
         id_ff        <= ENTITY_ID_BITS'(req_ch.entity_id);
         type_ff      <= req_ch.entity_type;
      end
      if (rsp_load) begin
         rsp_status_ff   <= ctl.status;
         rsp_slot_ff     <= ctl.slot;
         rsp_found_id_ff <= ctl.found_id;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.slot     = rsp_slot_ff;
   assign rsp_ch.found_id = rsp_found_id_ff;

   // A read and a write never share a cycle, so no read can see a stale tile.
   `TSOT_ASSERT_ALWAYS(a_no_rd_wr_overlap, clock, reset,
      !(ram_wr_en && ram_rd_en),
      "RAM read and write in the same cycle")
   // Every accepted transaction is evaluated in the following cycle.
   `TSOT_ASSERT_NEXT(a_accept_to_eval, clock, reset,
      req_accept, state_ff == tsot_pkg::ST_EVAL,
      "accepted transaction not evaluated next cycle")
   // A new response appears only right after an evaluation.
   `TSOT_ASSERT_IMPLY(a_rsp_from_eval, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff == tsot_pkg::ST_EVAL),
      "response raised outside evaluation")
   // The second write of a move always follows its source clear.
   `TSOT_ASSERT_IMPLY(a_move_wr_order, clock, reset,
      state_ff == tsot_pkg::ST_MOVE_WR, $past(state_ff == tsot_pkg::ST_EVAL && ram_wr_en),
      "target fill without preceding source clear")

endmodule

`default_nettype wire
